// ===== hdl/dhr_pkg.sv =====
package dhr_pkg;

  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int KEY_W      = 64;
  localparam int SEQ_W      = 32;
  localparam int ACT_W      = 16;
  localparam int OUTC_W     = 8;
  localparam int CMT_W      = 8;
  localparam int REQ_W      = 7;
  localparam int CMD_W      = 2;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 128;

  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RECENT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // key in the low bits, committed at the top
  typedef struct packed {
    logic [CMT_W-1:0]  committed;
    logic [OUTC_W-1:0] outcome;
    logic [ACT_W-1:0]  action;
    logic [SEQ_W-1:0]  seq;
    logic [KEY_W-1:0]  key;
  } dhr_entry_t;

  // classified command as queued between front and back
  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [KEY_W-1:0]  key;
    logic [ACT_W-1:0]  action;
    logic [OUTC_W-1:0] outcome;
    logic [CMT_W-1:0]  committed;
    logic [REQ_W-1:0]  max_cnt;   // min(want_count, out_limit)
  } dhr_cmd_t;

endpackage

// ===== hdl/dhr_front.sv =====
module dhr_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // key, action, outcome, committed, want_count, out_limit (low bit up)
  input  logic [dhr_pkg::IN_DATA_W-1:0] in_tdata,
  // cmd
  input  logic [dhr_pkg::CMD_W-1:0]     in_tuser,
  output logic                          q_valid,
  input  logic                          q_ready,
  output dhr_pkg::dhr_cmd_t             q_cmd
);
  import dhr_pkg::*;

  dhr_cmd_t         q_mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;
  dhr_cmd_t         cls;
  logic [REQ_W-1:0] want, limit;

  always_comb begin
    want          = in_tdata[102:96];
    limit         = in_tdata[109:103];
    cls.op        = in_tuser;
    cls.key       = in_tdata[63:0];
    cls.action    = in_tdata[79:64];
    cls.outcome   = in_tdata[87:80];
    cls.committed = in_tdata[95:88];
    cls.max_cnt   = (want < limit) ? want : limit;
  end

  assign in_tready = (cnt_r != 2'd2);
  // unused command codes are taken and dropped here
  assign push      = in_tvalid && in_tready && (in_tuser != CMD_NONE);
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_cmd     = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hdl/dhr_back.sv =====
module dhr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  dhr_pkg::dhr_cmd_t              q_cmd,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // entry_key, entry_seq, entry_action, entry_outcome, entry_committed (low bit up)
  output logic [dhr_pkg::OUT_DATA_W-1:0] out_tdata,
  // item_valid
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import dhr_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  dhr_entry_t       mem [RING_DEPTH];
  dhr_entry_t       rd_data_r;
  logic [PTR_W-1:0] rd_addr;

  logic [1:0]       state_r, state_nxt;
  logic [SEQ_W-1:0] write_head_r, write_head_nxt;
  logic [PTR_W-1:0] head_slot_r, head_slot_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             lookup_r, lookup_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  logic             out_valid_r;
  dhr_entry_t       out_entry_r;
  logic             out_found_r, out_last_r;

  logic             out_free, out_load, load_found, load_last, wr_en, step;
  dhr_entry_t       load_entry, wr_entry;
  logic [CNT_W-1:0] populated, recent_n;
  logic [PTR_W-1:0] ptr_dec, start_ptr;

  assign out_free  = !out_valid_r || out_tready;
  assign populated = (write_head_r < SEQ_W'(RING_DEPTH)) ? write_head_r[CNT_W-1:0]
                                                          : CNT_W'(RING_DEPTH);
  assign recent_n  = (q_cmd.max_cnt < REQ_W'(populated)) ? CNT_W'(q_cmd.max_cnt) : populated;
  assign ptr_dec   = (ptr_r == '0) ? PTR_W'(RING_DEPTH - 1) : ptr_r - PTR_W'(1);
  assign start_ptr = (head_slot_r == '0) ? PTR_W'(RING_DEPTH - 1) : head_slot_r - PTR_W'(1);

  always_comb begin
    wr_entry.key       = q_cmd.key;
    wr_entry.seq       = write_head_r;
    wr_entry.action    = q_cmd.action;
    wr_entry.outcome   = q_cmd.outcome;
    wr_entry.committed = q_cmd.committed;
  end

  always_comb begin
    state_nxt      = state_r;
    write_head_nxt = write_head_r;
    head_slot_nxt  = head_slot_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    lookup_nxt     = lookup_r;
    key_nxt        = key_r;
    q_ready        = 1'b0;
    wr_en          = 1'b0;
    step           = 1'b0;
    out_load       = 1'b0;
    load_found     = 1'b0;
    load_last      = 1'b0;
    load_entry     = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_ready = 1'b1;
          case (q_cmd.op)
            CMD_RECORD: begin
              wr_en          = 1'b1;
              write_head_nxt = write_head_r + SEQ_W'(1);
              // slot follows head mod depth, also across the 32-bit wrap
              head_slot_nxt  = (write_head_r == '1 || head_slot_r == PTR_W'(RING_DEPTH - 1))
                               ? '0 : head_slot_r + PTR_W'(1);
            end
            CMD_LOOKUP: begin
              if (populated == '0) begin
                out_load  = 1'b1;
                load_last = 1'b1;
              end else begin
                lookup_nxt = 1'b1;
                key_nxt    = q_cmd.key;
                rem_nxt    = populated;
                ptr_nxt    = start_ptr;
                state_nxt  = S_PRIME;
              end
            end
            CMD_RECENT: begin
              if (recent_n == '0) begin
                out_load  = 1'b1;
                load_last = 1'b1;
              end else begin
                lookup_nxt = 1'b0;
                rem_nxt    = recent_n;
                ptr_nxt    = start_ptr;
                state_nxt  = S_PRIME;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PRIME: begin
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (lookup_r) begin
          if (rd_data_r.key == key_r) begin
            if (out_free) begin
              out_load   = 1'b1;
              load_found = 1'b1;
              load_last  = 1'b1;
              load_entry = rd_data_r;
              state_nxt  = S_IDLE;
            end
          end else if (rem_r == CNT_W'(1)) begin
            if (out_free) begin
              out_load  = 1'b1;
              load_last = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            step = 1'b1;
          end
        end else if (out_free) begin
          out_load   = 1'b1;
          load_found = 1'b1;
          load_entry = rd_data_r;
          load_last  = (rem_r == CNT_W'(1));
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (step) begin
      rem_nxt = rem_r - CNT_W'(1);
      ptr_nxt = ptr_dec;
    end
  end

  // read data always belongs to ptr_r while walking
  assign rd_addr = step ? ptr_dec : ptr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head_slot_r] <= wr_entry;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      write_head_r <= '0;
      head_slot_r  <= '0;
      ptr_r        <= '0;
      rem_r        <= '0;
      lookup_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      write_head_r <= write_head_nxt;
      head_slot_r  <= head_slot_nxt;
      ptr_r        <= ptr_nxt;
      rem_r        <= rem_nxt;
      lookup_r     <= lookup_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (out_load) begin
      out_entry_r <= load_entry;
      out_found_r <= load_found;
      out_last_r  <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_entry_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_walk_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> rem_r != '0)
    else $error("walk with no entries left");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  a_head_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready && q_cmd.op == CMD_RECORD)
      |=> write_head_r == $past(write_head_r) + 32'd1)
    else $error("head did not advance on record");

  a_prime_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRIME |-> (rem_r <= populated && rem_r != '0))
    else $error("walk length exceeds populated entries");

  a_busy_noq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !q_ready)
    else $error("queue popped while walking");
`endif

endmodule

// ===== hdl/decision_history_ring_unit.sv =====
// Decision history ring: keeps the most recent RING_DEPTH decision records.
// Input stream (in_*): in_tuser carries the command (record, lookup, recent),
// in_tdata the key, record fields and the recent-read counts. A record writes
// the slot at the head, stamps the head as its sequence number and gives no
// output. A lookup returns one transaction: the newest entry with that key
// (tuser=1) or a zeroed not-found result (tuser=0). A recent read returns up
// to min(want, limit, populated) entries newest first, tlast on the final one,
// or one zeroed result with tuser=0 when there is nothing to give.
// Commands go through a two-entry queue into the executor. A record is written
// in S_IDLE; a lookup or recent read primes the read in S_PRIME, then visits one
// entry per cycle in S_WALK (up to RING_DEPTH), set by the single registered read
// port of the record store, and pauses while a result waits for the output. The
// first result is loaded from S_WALK, or from S_IDLE for an empty ring.
// Reset clears the head and the queue; the store is not cleared and only
// populated entries are ever returned. While out_tready is low the output register
// holds its transaction and the walk pauses once it has a transaction to hand
// over; the queue keeps taking input until it is full.
module decision_history_ring_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // key, action, outcome, committed, want_count, out_limit (low bit up)
  input  logic [dhr_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [dhr_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // entry_key, entry_seq, entry_action, entry_outcome, entry_committed (low bit up)
  output logic [dhr_pkg::OUT_DATA_W-1:0] out_tdata,
  // item_valid
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import dhr_pkg::*;

  logic     q_valid, q_ready;
  dhr_cmd_t q_cmd;

  dhr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd)
  );

  dhr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_cmd      (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/decision_history_ring_unit_test.sv =====
`timescale 1ns / 100ps

module decision_history_ring_unit_test;
  import dhr_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SQUEEZE_LEN  = 400;
  localparam int ITEMS_PHASE  = 40;
  localparam int DRAIN_CYCLES = RING_DEPTH + 24;

  typedef enum logic {CHK_MODEL, CHK_TYPED} chk_t;

  // one result transaction as seen on the output stream
  typedef struct packed {
    logic       valid;
    dhr_entry_t ent;
    logic       last;
  } ring_reply_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [ACT_W-1:0]  action;
    logic [OUTC_W-1:0] outcome;
    logic [CMT_W-1:0]  committed;
    logic [REQ_W-1:0]  want;
    logic [REQ_W-1:0]  limit;
    chk_t              chk;
    ring_reply_t       reply;
  } ring_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = CMD_NONE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  // predictor state
  dhr_entry_t  hist_mem [RING_DEPTH];
  logic [31:0] hist_head = '0;
  ring_reply_t pending_replies [$];

  int          errors = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          squeeze_go = 1'b0;
  bit          squeeze_done = 1'b0;
  int          squeeze_left = 0;
  logic [KEY_W-1:0] key_pool [8];

  decision_history_ring_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  function automatic ring_req_t mk(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                   logic [ACT_W-1:0] act, logic [OUTC_W-1:0] oc,
                                   logic [CMT_W-1:0] cm, logic [REQ_W-1:0] want,
                                   logic [REQ_W-1:0] limit);
    ring_req_t r;
    r.cmd       = cmd;
    r.key       = key;
    r.action    = act;
    r.outcome   = oc;
    r.committed = cm;
    r.want      = want;
    r.limit     = limit;
    r.chk       = CHK_MODEL;
    r.reply     = '0;
    return r;
  endfunction

  // single zeroed not-found / nothing-to-give transaction
  function automatic ring_req_t miss(ring_req_t r);
    r.chk   = CHK_TYPED;
    r.reply = '{valid: 1'b0, ent: '0, last: 1'b1};
    return r;
  endfunction

  function automatic ring_req_t hit(ring_req_t r, logic [SEQ_W-1:0] seq,
                                    logic [ACT_W-1:0] act, logic [OUTC_W-1:0] oc,
                                    logic [CMT_W-1:0] cm);
    r.chk   = CHK_TYPED;
    r.reply = '{valid: 1'b1,
                ent: '{key: r.key, seq: seq, action: act, outcome: oc, committed: cm},
                last: 1'b1};
    return r;
  endfunction

  function automatic ring_req_t rand_req();
    int unsigned sel;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [REQ_W-1:0] want;
    logic [REQ_W-1:0] limit;
    sel = $urandom_range(99);
    if (sel < 45) begin
      cmd = CMD_RECORD;
    end else if (sel < 70) begin
      cmd = CMD_LOOKUP;
    end else if (sel < 95) begin
      cmd = CMD_RECENT;
    end else begin
      cmd = CMD_NONE;
    end
    // small key pool so lookups hit and duplicates get shadowed
    if ($urandom_range(9) < 8) begin
      key = key_pool[$urandom_range(7)];
    end else begin
      key = {$urandom, $urandom};
    end
    want  = ($urandom_range(3) == 0) ? REQ_W'($urandom_range(64)) : REQ_W'($urandom_range(18));
    limit = ($urandom_range(3) == 0) ? REQ_W'($urandom_range(64)) : REQ_W'($urandom_range(18));
    return mk(cmd, key, ACT_W'($urandom), OUTC_W'($urandom), CMT_W'($urandom), want, limit);
  endfunction

  function automatic void ring_predict(ring_req_t r, bit emit);
    int unsigned fill;
    int unsigned n;
    logic [31:0] back;
    ring_reply_t rep;
    fill = (hist_head < RING_DEPTH) ? hist_head : RING_DEPTH;
    rep  = '{valid: 1'b0, ent: '0, last: 1'b1};
    case (r.cmd)
      CMD_RECORD: begin
        hist_mem[hist_head % RING_DEPTH] = '{key: r.key, seq: hist_head, action: r.action,
                                             outcome: r.outcome, committed: r.committed};
        hist_head = hist_head + 32'd1;
      end
      CMD_LOOKUP: begin
        for (int unsigned k = 0; k < fill; k++) begin
          back = hist_head - 32'd1 - k;
          if (hist_mem[back % RING_DEPTH].key == r.key) begin
            rep.valid = 1'b1;
            rep.ent   = hist_mem[back % RING_DEPTH];
            break;
          end
        end
        if (emit) pending_replies.push_back(rep);
      end
      CMD_RECENT: begin
        n = r.want;
        if (n > r.limit) n = r.limit;
        if (n > fill) n = fill;
        if (emit && n == 0) pending_replies.push_back(rep);
        for (int unsigned k = 0; emit && k < n; k++) begin
          back = hist_head - 32'd1 - k;
          rep.valid = 1'b1;
          rep.ent   = hist_mem[back % RING_DEPTH];
          rep.last  = (k + 1 == n);
          pending_replies.push_back(rep);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(input ring_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {2'b00, r.limit, r.want, r.committed, r.outcome, r.action, r.key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ring_predict(r, r.chk == CHK_MODEL);
    if (r.chk == CHK_TYPED) pending_replies.push_back(r.reply);
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // receiver: random stalls, plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (squeeze_left != 0) begin
      squeeze_left = squeeze_left - 1;
      out_tready <= 1'b0;
    end else if (squeeze_go && !squeeze_done) begin
      squeeze_done = 1'b1;
      squeeze_left = SQUEEZE_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : reply_check
    ring_reply_t got;
    ring_reply_t exp_r;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.valid         = out_tuser;
      got.last          = out_tlast;
      got.ent.key       = out_tdata[63:0];
      got.ent.seq       = out_tdata[95:64];
      got.ent.action    = out_tdata[111:96];
      got.ent.outcome   = out_tdata[119:112];
      got.ent.committed = out_tdata[127:120];
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_replies.pop_front();
        check_field("item_valid", exp_r.valid, got.valid);
        check_field("entry_key", exp_r.ent.key, got.ent.key);
        check_field("entry_seq", exp_r.ent.seq, got.ent.seq);
        check_field("entry_action", exp_r.ent.action, got.ent.action);
        check_field("entry_outcome", exp_r.ent.outcome, got.ent.outcome);
        check_field("entry_committed", exp_r.ent.committed, got.ent.committed);
        check_field("last_item", exp_r.last, got.last);
      end
    end
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("decision_history_ring_unit test failed");
    $finish;
  end

  initial begin : stimulus
    ring_req_t dir_rows [$];
    logic [KEY_W-1:0] ones;
    logic [KEY_W-1:0] dup_key;
    ones    = '1;
    dup_key = 64'h0123_4567_89AB_CDEF;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty ring, unused code, extremes, duplicate keys, zero counts
    dir_rows.push_back(miss(mk(CMD_LOOKUP, '0, '0, '0, '0, '0, '0)));
    dir_rows.push_back(miss(mk(CMD_RECENT, ones, '0, '0, '0, 7'd64, 7'd64)));
    dir_rows.push_back(mk(CMD_NONE, ones, '1, '1, '1, 7'd127, 7'd127));
    dir_rows.push_back(mk(CMD_RECORD, ones, 16'hFFFF, 8'hFF, 8'hFF, '0, '0));
    dir_rows.push_back(hit(mk(CMD_LOOKUP, ones, '0, '0, '0, '0, '0),
                           32'd0, 16'hFFFF, 8'hFF, 8'hFF));
    dir_rows.push_back(mk(CMD_RECORD, '0, '0, '0, '0, 7'd63, 7'd63));
    dir_rows.push_back(hit(mk(CMD_LOOKUP, '0, '1, '1, '1, 7'd64, 7'd64),
                           32'd1, '0, '0, '0));
    dir_rows.push_back(miss(mk(CMD_RECENT, '0, '0, '0, '0, 7'd0, 7'd64)));
    dir_rows.push_back(miss(mk(CMD_RECENT, '0, '0, '0, '0, 7'd64, 7'd0)));
    dir_rows.push_back(mk(CMD_RECENT, '0, '0, '0, '0, 7'd64, 7'd64));
    dir_rows.push_back(mk(CMD_RECORD, dup_key, 16'h5A5A, 8'hA5, 8'h01, '0, '0));
    dir_rows.push_back(mk(CMD_RECORD, dup_key, 16'hA5A5, 8'h5A, 8'h00, '0, '0));
    dir_rows.push_back(hit(mk(CMD_LOOKUP, dup_key, '0, '0, '0, '0, '0),
                           32'd3, 16'hA5A5, 8'h5A, 8'h00));
    dir_rows.push_back(miss(mk(CMD_LOOKUP, 64'h8000_0000_0000_0000, '0, '0, '0, '0, '0)));
    dir_rows.push_back(mk(CMD_RECENT, '0, '0, '0, '0, 7'd1, 7'd64));
    dir_rows.push_back(mk(CMD_RECENT, '0, '0, '0, '0, 7'd63, 7'd1));
    dir_rows.push_back(mk(CMD_RECENT, '0, '0, '0, '0, 7'd3, 7'd2));
    dir_rows.push_back(mk(CMD_NONE, '0, '0, '0, '0, '0, '0));
    dir_rows.push_back(mk(CMD_RECENT, '0, '0, '0, '0, 7'd63, 7'd63));
    foreach (dir_rows[i]) send_req(dir_rows[i]);

    // phases: no idling, sender idle, receiver stall, both, long receiver hold-off
    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph == 1) ? 81 : (ph == 3) ? 14 : 0;
      stall_pct    <= (ph == 2) ? 81 : (ph == 3) ? 14 : 0;
      if (ph == 4) squeeze_go <= 1'b1;
      for (int i = 0; i < ITEMS_PHASE; i++) send_req(rand_req());
    end
    in_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("decision_history_ring_unit test passed");
    end else begin
      $display("decision_history_ring_unit test failed");
    end
    $finish;
  end

endmodule
